/* hdl/midpoint_line_rasterizer_unit_macros.svh */
// assertion macros shared by the line rasterizer modules
`ifndef MIDPOINT_LINE_RASTERIZER_UNIT_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define MLR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked outside reset
`define MLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MLR_ASSERT_NOW(lbl, ante, cons, msg)
`define MLR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/mlr_pkg.sv */
// types, codes and helpers for the midpoint line rasterizer
package mlr_pkg;

    localparam int COORD_BITS = 9;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int RISE_BITS  = COORD_BITS + 2;
    localparam int TERM_BITS  = COORD_BITS + 3;
    localparam int SUM_BITS   = TERM_BITS + 2;
    localparam int KIND_BITS  = 3;

    localparam logic [KIND_BITS-1:0] KIND_ACCEPTED = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_STEEP    = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_EMPTY    = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_PIXEL    = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_IDLE     = 3'd4;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam int TERM_MAX_I = 2 ** (TERM_BITS - 1) - 1;
    localparam logic signed [SUM_BITS-1:0] SUM_HI = SUM_BITS'(TERM_MAX_I);
    localparam logic signed [SUM_BITS-1:0] SUM_LO = SUM_BITS'(-TERM_MAX_I - 1);

    typedef struct packed {
        logic                  req_type;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
    } req_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  last_pixel;
    } rsp_t;

    // classified request as it travels from front to back
    typedef struct packed {
        logic                        is_step;
        logic [KIND_BITS-1:0]        start_kind;
        logic [COORD_BITS-1:0]       x_start;
        logic [COORD_BITS-1:0]       y_start;
        logic [COORD_BITS-1:0]       x_end;
        logic signed [RISE_BITS-1:0] twice_rise;
        logic signed [RISE_BITS-1:0] twice_run;
        logic signed [TERM_BITS-1:0] term;
    } cmd_t;

    function automatic logic signed [TERM_BITS-1:0] clamp_term(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [TERM_BITS-1:0] r;
        if (v > SUM_HI)
            r = TERM_BITS'(SUM_HI);
        else if (v < SUM_LO)
            r = TERM_BITS'(SUM_LO);
        else
            r = TERM_BITS'(v);
        return r;
    endfunction

endpackage

/* hdl/midpoint_line_rasterizer_unit.sv */
// top level of the first-octant midpoint line rasterizer
//
// requests arrive on req_valid/req_ready with the req struct: a start request
// (req_type 0) loads both end points and returns one status, a step request
// (req_type 1) returns the next pixel of the active line or an idle status.
// every request yields exactly one response on rsp_valid/rsp_ready.
// the front classifies a start (steep, empty or accepted) and precomputes the
// doubled rise, run and first midpoint term; a queue of QUEUE_DEPTH entries
// decouples it from the back, which holds the line state and per request does
// an add, a conditional subtract, compares and a saturate into a registered
// response. with the queue empty a request passes through the queue entry
// and then the response register before its response is valid.
// throughput: one request per clock while the receiver takes each response.
// req_ready stays high while the queue has room, so requests keep flowing
// while a finished response waits; when the receiver stalls the response
// holds and the queue fills before req_ready drops.
// reset clears the active line, empties the queue and drops rsp_valid.
module midpoint_line_rasterizer_unit
    import mlr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic back_valid;
    logic back_ready;

    mlr_front u_front
    (
        .req (req),
        .cmd (front_cmd)
    );

    mlr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (req_valid),
        .push_ready (req_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    mlr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* hdl/mlr_front.sv */
// front end: classifies start requests and builds the queue entry
module mlr_front
    import mlr_pkg::*;
(
    input  req_t req,
    output cmd_t cmd
);

    logic signed [DIFF_BITS-1:0] dx;
    logic signed [DIFF_BITS-1:0] dy;
    logic                        steep;
    logic                        backward;

    always_comb
    begin
        dx = $signed({1'b0, req.x_end}) - $signed({1'b0, req.x_start});
        dy = $signed({1'b0, req.y_end}) - $signed({1'b0, req.y_start});

        // slope above one in either direction, or rising vertical
        steep = (!dx[DIFF_BITS-1] && (dx != '0) && (dy > dx)) ||
                (dx[DIFF_BITS-1] && (dy < dx)) ||
                ((dx == '0) && !dy[DIFF_BITS-1] && (dy != '0));
        backward = dx[DIFF_BITS-1];

        cmd.is_step    = (req.req_type == REQ_STEP);
        cmd.x_start    = req.x_start;
        cmd.y_start    = req.y_start;
        cmd.x_end      = req.x_end;
        cmd.twice_rise = {dy, 1'b0};
        cmd.twice_run  = {dx, 1'b0};
        // 2dy - dx always fits the term range here
        cmd.term       = TERM_BITS'({dy[DIFF_BITS-1], dy, 1'b0})
                       - TERM_BITS'({{2{dx[DIFF_BITS-1]}}, dx});

        if (steep)
            cmd.start_kind = KIND_STEEP;
        else if (backward)
            cmd.start_kind = KIND_EMPTY;
        else
            cmd.start_kind = KIND_ACCEPTED;
    end

endmodule

/* hdl/mlr_queue.sv */
// small request queue between front and back
`include "midpoint_line_rasterizer_unit_macros.svh"

module mlr_queue
    import mlr_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    cmd_t                entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == PTR_BITS'(DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            if (rd_ptr_reg == PTR_BITS'(DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    `MLR_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_BITS'(DEPTH), "queue count overflow")
    `MLR_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count missed a request")
    `MLR_ASSERT_NEXT(a_count_down, pop && !push, count_reg == $past(count_reg) - 1'b1, "queue count missed a pop")

endmodule

/* hdl/mlr_back.sv */
// back end: line state, midpoint stepping and the output register
`include "midpoint_line_rasterizer_unit_macros.svh"

module mlr_back
    import mlr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic                        active_reg;
    logic                        active_next;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    rsp_t                        rsp_reg;
    rsp_t                        rsp_next;
    logic [COORD_BITS-1:0]       cur_x_reg;
    logic [COORD_BITS-1:0]       cur_x_next;
    logic [COORD_BITS-1:0]       cur_y_reg;
    logic [COORD_BITS-1:0]       cur_y_next;
    logic [COORD_BITS-1:0]       final_x_reg;
    logic [COORD_BITS-1:0]       final_x_next;
    logic signed [TERM_BITS-1:0] term_reg;
    logic signed [TERM_BITS-1:0] term_next;
    logic signed [RISE_BITS-1:0] rise_reg;
    logic signed [RISE_BITS-1:0] rise_next;
    logic signed [RISE_BITS-1:0] run_reg;
    logic signed [RISE_BITS-1:0] run_next;
    logic                        pop;
    logic                        at_end;
    logic                        y_up;
    logic signed [SUM_BITS-1:0]  sum;

    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign at_end    = (cur_x_reg == final_x_reg);
    assign y_up      = !term_reg[TERM_BITS-1] && (term_reg != '0);

    always_comb
    begin
        sum = SUM_BITS'(term_reg) + SUM_BITS'(rise_reg);
        if (y_up)
            sum = sum - SUM_BITS'(run_reg);
    end

    always_comb
    begin
        active_next    = active_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        final_x_next   = final_x_reg;
        term_next      = term_reg;
        rise_next      = rise_reg;
        run_next       = run_reg;

        if (pop)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            if (!cmd.is_step)
            begin
                rsp_next.kind = cmd.start_kind;
                active_next   = (cmd.start_kind == KIND_ACCEPTED);
                if (cmd.start_kind == KIND_ACCEPTED)
                begin
                    cur_x_next   = cmd.x_start;
                    cur_y_next   = cmd.y_start;
                    final_x_next = cmd.x_end;
                    term_next    = cmd.term;
                    rise_next    = cmd.twice_rise;
                    run_next     = cmd.twice_run;
                end
            end
            else if (!active_reg)
            begin
                rsp_next.kind = KIND_IDLE;
            end
            else
            begin
                rsp_next.kind       = KIND_PIXEL;
                rsp_next.pixel_x    = cur_x_reg;
                rsp_next.pixel_y    = cur_y_reg;
                rsp_next.last_pixel = at_end;
                if (at_end)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    term_next  = clamp_term(sum);
                    cur_x_next = cur_x_reg + 1'b1;
                    if (y_up)
                        cur_y_next = cur_y_reg + 1'b1;
                end
            end
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg     <= rsp_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        final_x_reg <= final_x_next;
        term_reg    <= term_next;
        rise_reg    <= rise_next;
        run_reg     <= run_next;
    end

    `MLR_ASSERT_NOW(a_x_in_span, active_reg, cur_x_reg <= final_x_reg, "active line ran past its end")
    `MLR_ASSERT_NEXT(a_last_ends, pop && cmd.is_step && active_reg && at_end, !active_reg && rsp.last_pixel, "last pixel did not end the line")
    `MLR_ASSERT_NEXT(a_x_steps, pop && cmd.is_step && active_reg && !at_end, cur_x_reg == $past(cur_x_reg) + 1'b1, "x did not advance on a pixel")

endmodule
